// File: src/md5cm_pkg.sv
// Shared types, constants and round tables for the MD5 candidate match core.
package md5cm_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CAND_W    = 64;
    localparam int unsigned ROUNDS    = 64;
    localparam int unsigned ROUND_W   = 6;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_A = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_B = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_C = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_D = 4'd3;

    localparam logic [WORD_W-1:0] INIT_A   = 32'h67452301;
    localparam logic [WORD_W-1:0] INIT_B   = 32'hefcdab89;
    localparam logic [WORD_W-1:0] INIT_C   = 32'h98badcfe;
    localparam logic [WORD_W-1:0] INIT_D   = 32'h10325476;
    localparam logic [WORD_W-1:0] PAD_MARK = 32'h00000080;
    localparam logic [WORD_W-1:0] MSG_BITS = 32'h00000040;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } t_md5_state;

    // Padded block word g: two candidate words, pad mark, bit length, zeros.
    function automatic logic [WORD_W-1:0] msg_word(input logic [CAND_W-1:0] cand,
                                                  input logic [3:0] g);
        logic [WORD_W-1:0] w;
        case (g)
            4'd0:    w = cand[31:0];
            4'd1:    w = cand[63:32];
            4'd2:    w = PAD_MARK;
            4'd14:   w = MSG_BITS;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [ROUND_W-1:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'b0000: s = 5'd7;
            4'b0001: s = 5'd12;
            4'b0010: s = 5'd17;
            4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;
            4'b0101: s = 5'd9;
            4'b0110: s = 5'd14;
            4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;
            4'b1001: s = 5'd11;
            4'b1010: s = 5'd16;
            4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;
            4'b1101: s = 5'd10;
            4'b1110: s = 5'd15;
            4'b1111: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] r);
        logic [WORD_W-1:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// File: src/md5cm_round.sv
// One MD5 round cell: applies a single round and registers state, candidate and valid.
module md5cm_round (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [md5cm_pkg::ROUND_W-1:0]       i_round,
    input  logic                                i_valid,
    input  md5cm_pkg::t_md5_state               i_state,
    input  logic [md5cm_pkg::CAND_W-1:0]        i_cand,
    output logic                                o_valid,
    output md5cm_pkg::t_md5_state               o_state,
    output logic [md5cm_pkg::CAND_W-1:0]        o_cand
);

    logic                               r_valid;
    md5cm_pkg::t_md5_state              r_state;
    logic [md5cm_pkg::CAND_W-1:0]       r_cand;
    md5cm_pkg::t_md5_state              n_state;

    logic [md5cm_pkg::WORD_W-1:0]       f;
    logic [md5cm_pkg::WORD_W-1:0]       x;
    logic [2*md5cm_pkg::WORD_W-1:0]     rot_wide;
    logic [3:0]                         g;
    logic [4:0]                         s;

    always_comb begin
        case (i_round[5:4])
            2'd0: begin
                f = (i_state.b & i_state.c) | (~i_state.b & i_state.d);
                g = i_round[3:0];
            end
            2'd1: begin
                f = (i_state.d & i_state.b) | (~i_state.d & i_state.c);
                g = 4'((i_round[3:0] << 2) + i_round[3:0] + 4'd1);
            end
            2'd2: begin
                f = i_state.b ^ i_state.c ^ i_state.d;
                g = 4'((i_round[3:0] << 1) + i_round[3:0] + 4'd5);
            end
            default: begin
                f = i_state.c ^ (i_state.b | ~i_state.d);
                g = 4'((i_round[3:0] << 3) - i_round[3:0]);
            end
        endcase
        s = md5cm_pkg::rot_amt(i_round);
        x = i_state.a + f + md5cm_pkg::round_k(i_round) + md5cm_pkg::msg_word(i_cand, g);
        rot_wide = {x, x} << s;
        n_state.a = i_state.d;
        n_state.d = i_state.c;
        n_state.c = i_state.b;
        n_state.b = i_state.b + rot_wide[2*md5cm_pkg::WORD_W-1:md5cm_pkg::WORD_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_cand  <= i_cand;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_cand  = r_cand;

endmodule

// File: src/md5cm_final.sv
// Output stage: adds the initial chaining values and compares against the target.
module md5cm_final (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  md5cm_pkg::t_md5_state       i_state,
    input  md5cm_pkg::t_md5_state       i_target,
    output logic                        o_valid,
    output md5cm_pkg::t_md5_state       o_digest,
    output logic                        o_match
);

    logic                       r_valid;
    md5cm_pkg::t_md5_state      r_digest;
    logic                       r_match;
    md5cm_pkg::t_md5_state      n_digest;

    always_comb begin
        n_digest.a = i_state.a + md5cm_pkg::INIT_A;
        n_digest.b = i_state.b + md5cm_pkg::INIT_B;
        n_digest.c = i_state.c + md5cm_pkg::INIT_C;
        n_digest.d = i_state.d + md5cm_pkg::INIT_D;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= i_valid;
            r_match <= i_valid && (n_digest == i_target);
        end
    end

    always_ff @(posedge i_clk) begin
        r_digest <= n_digest;
    end

    assign o_valid  = r_valid;
    assign o_digest = r_digest;
    assign o_match  = r_match;

endmodule

// File: src/md5_candidate_match_core.sv
// A candidate passes through the 64 round cells and then the output add/compare stage,
// each of which registers its result.
// Throughput: one candidate per cycle; o_busy is never raised.
// Results cannot be stalled: o_valid is a one-cycle strobe.
// Reset (synchronous, active low) clears all valid bits and the target registers.
module md5_candidate_match_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [md5cm_pkg::CAND_W-1:0]         i_candidate,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [md5cm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [md5cm_pkg::WORD_W-1:0]         i_cfg_data,
    output logic                                 o_valid,
    output logic [md5cm_pkg::WORD_W-1:0]         o_digest_a,
    output logic [md5cm_pkg::WORD_W-1:0]         o_digest_b,
    output logic [md5cm_pkg::WORD_W-1:0]         o_digest_c,
    output logic [md5cm_pkg::WORD_W-1:0]         o_digest_d,
    output logic                                 o_match
);

    md5cm_pkg::t_md5_state              r_target;
    md5cm_pkg::t_md5_state              w_iv;
    md5cm_pkg::t_md5_state              w_digest;

    logic                               w_valid [0:md5cm_pkg::ROUNDS];
    md5cm_pkg::t_md5_state              w_state [0:md5cm_pkg::ROUNDS];
    logic [md5cm_pkg::CAND_W-1:0]       w_cand  [0:md5cm_pkg::ROUNDS];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                md5cm_pkg::REG_TARGET_A: r_target.a <= i_cfg_data;
                md5cm_pkg::REG_TARGET_B: r_target.b <= i_cfg_data;
                md5cm_pkg::REG_TARGET_C: r_target.c <= i_cfg_data;
                md5cm_pkg::REG_TARGET_D: r_target.d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_iv.a = md5cm_pkg::INIT_A;
        w_iv.b = md5cm_pkg::INIT_B;
        w_iv.c = md5cm_pkg::INIT_C;
        w_iv.d = md5cm_pkg::INIT_D;
    end

    assign w_valid[0] = i_start && !o_busy;
    assign w_state[0] = w_iv;
    assign w_cand[0]  = i_candidate;

    genvar gi;
    generate
        for (gi = 0; gi < md5cm_pkg::ROUNDS; gi++) begin : g_round
            md5cm_round u_round (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_round (md5cm_pkg::ROUND_W'(gi)),
                .i_valid (w_valid[gi]),
                .i_state (w_state[gi]),
                .i_cand  (w_cand[gi]),
                .o_valid (w_valid[gi+1]),
                .o_state (w_state[gi+1]),
                .o_cand  (w_cand[gi+1])
            );
        end
    endgenerate

    md5cm_final u_final (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[md5cm_pkg::ROUNDS]),
        .i_state  (w_state[md5cm_pkg::ROUNDS]),
        .i_target (r_target),
        .o_valid  (o_valid),
        .o_digest (w_digest),
        .o_match  (o_match)
    );

    assign o_digest_a = w_digest.a;
    assign o_digest_b = w_digest.b;
    assign o_digest_c = w_digest.c;
    assign o_digest_d = w_digest.d;

    // A result strobe always traces back to an earlier accepted beat.
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 65))
        else $error("result strobe without matching accepted beat");

    // The first round cell picks up every accepted beat on the next cycle.
    a_cell0_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> w_valid[1])
        else $error("accepted beat lost at first round cell");

    a_match_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_match |-> o_valid)
        else $error("match flag raised without a result strobe");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the MD5 candidate match core: digest predictor plus scoreboard.
`timescale 1ns / 100ps

module tb_top;

    localparam int LATENCY         = 65;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DIRECTED_ROWS   = 14;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 102;
    localparam int MAX_REPORTS     = 10;

    // Well-known MD5 vectors: "password" and "12345678"
    localparam logic [md5cm_pkg::CAND_W-1:0] PWD_CAND = 64'h64726f7773736170;
    localparam logic [md5cm_pkg::WORD_W-1:0] PWD_A    = 32'h3bcc4d5f;
    localparam logic [md5cm_pkg::WORD_W-1:0] PWD_B    = 32'hd665a75a;
    localparam logic [md5cm_pkg::WORD_W-1:0] PWD_C    = 32'hde27831d;
    localparam logic [md5cm_pkg::WORD_W-1:0] PWD_D    = 32'h99cf82b8;
    localparam logic [md5cm_pkg::CAND_W-1:0] NUM_CAND = 64'h3837363534333231;

    typedef struct packed {
        logic [md5cm_pkg::WORD_W-1:0] a;
        logic [md5cm_pkg::WORD_W-1:0] b;
        logic [md5cm_pkg::WORD_W-1:0] c;
        logic [md5cm_pkg::WORD_W-1:0] d;
        logic                         match;
    } t_digest;

    typedef struct packed {
        logic [md5cm_pkg::CAND_W-1:0] cand;
        logic                         typed;
        t_digest                      res;
    } t_dir_row;

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_start     = 1'b0;
    logic [md5cm_pkg::CAND_W-1:0]    i_candidate = '0;
    logic                            i_cfg_valid = 1'b0;
    logic [md5cm_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [md5cm_pkg::WORD_W-1:0]    i_cfg_data  = '0;
    logic                            o_busy;
    logic                            o_cfg_ready;
    logic                            o_valid;
    logic [md5cm_pkg::WORD_W-1:0]    o_digest_a;
    logic [md5cm_pkg::WORD_W-1:0]    o_digest_b;
    logic [md5cm_pkg::WORD_W-1:0]    o_digest_c;
    logic [md5cm_pkg::WORD_W-1:0]    o_digest_d;
    logic                            o_match;

    logic [md5cm_pkg::WORD_W-1:0] md5_k [0:md5cm_pkg::ROUNDS-1];
    logic [md5cm_pkg::WORD_W-1:0] tgt_a = '0;
    logic [md5cm_pkg::WORD_W-1:0] tgt_b = '0;
    logic [md5cm_pkg::WORD_W-1:0] tgt_c = '0;
    logic [md5cm_pkg::WORD_W-1:0] tgt_d = '0;
    t_digest                      pending_digests [$];
    int                           mismatches = 0;
    int                           burst_left = 0;

    md5_candidate_match_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_candidate (i_candidate),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_digest_a  (o_digest_a),
        .o_digest_b  (o_digest_b),
        .o_digest_c  (o_digest_c),
        .o_digest_d  (o_digest_d),
        .o_match     (o_match)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Round constants: floor(|sin(i+1)| * 2^32)
    initial begin
        real         r;
        logic [63:0] kv;
        for (int i = 0; i < md5cm_pkg::ROUNDS; i++) begin
            r = $sin($itor(i + 1));
            if (r < 0.0) r = -r;
            r = $floor(r * 4294967296.0);
            kv = r;
            md5_k[i] = kv[31:0];
        end
    end

    function automatic int md5_shift(input int i);
        int col;
        col = i % 4;
        case (i / 16)
            0:       return (col == 0) ? 7 : (col == 1) ? 12 : (col == 2) ? 17 : 22;
            1:       return (col == 0) ? 5 : (col == 1) ? 9  : (col == 2) ? 14 : 20;
            2:       return (col == 0) ? 4 : (col == 1) ? 11 : (col == 2) ? 16 : 23;
            default: return (col == 0) ? 6 : (col == 1) ? 10 : (col == 2) ? 15 : 21;
        endcase
    endfunction

    function automatic t_digest md5_expect(input logic [md5cm_pkg::CAND_W-1:0] cand);
        logic [md5cm_pkg::WORD_W-1:0] blk [0:15];
        logic [md5cm_pkg::WORD_W-1:0] a, b, c, d, f, x, t;
        int                           g, s;
        t_digest                      r;
        for (int w = 0; w < 16; w++) blk[w] = '0;
        blk[0]  = cand[31:0];
        blk[1]  = cand[63:32];
        blk[2]  = 32'h00000080;   // pad mark right after the 8 message bytes
        blk[14] = 32'd64;         // message length in bits
        a = 32'h67452301;
        b = 32'hefcdab89;
        c = 32'h98badcfe;
        d = 32'h10325476;
        for (int i = 0; i < md5cm_pkg::ROUNDS; i++) begin
            if (i < 16) begin
                f = (b & c) | (~b & d);
                g = i;
            end else if (i < 32) begin
                f = (d & b) | (~d & c);
                g = (5 * i + 1) % 16;
            end else if (i < 48) begin
                f = b ^ c ^ d;
                g = (3 * i + 5) % 16;
            end else begin
                f = c ^ (b | ~d);
                g = (7 * i) % 16;
            end
            x = a + f + md5_k[i] + blk[g];
            s = md5_shift(i);
            t = d;
            d = c;
            c = b;
            b = b + ((x << s) | (x >> (32 - s)));
            a = t;
        end
        r.a = a + 32'h67452301;
        r.b = b + 32'hefcdab89;
        r.c = c + 32'h98badcfe;
        r.d = d + 32'h10325476;
        r.match = (r.a == tgt_a) && (r.b == tgt_b) && (r.c == tgt_c) && (r.d == tgt_d);
        return r;
    endfunction

    function automatic t_dir_row directed_vector(input int i);
        t_dir_row v;
        v.typed = 1'b0;
        v.res   = '0;
        case (i)
            0:  v.cand = '0;
            1:  v.cand = '1;
            2:  begin
                v.cand  = NUM_CAND;
                v.typed = 1'b1;
                v.res   = {32'hd25ad525, 32'h0a40aa83, 32'h6dc764f4, 32'had073c71, 1'b0};
            end
            3:  begin
                v.cand  = PWD_CAND;
                v.typed = 1'b1;
                v.res   = {PWD_A, PWD_B, PWD_C, PWD_D, 1'b0};
            end
            4:  v.cand = 64'h8080808080808080;   // every byte with its top bit set
            5:  v.cand = 64'h0000000000000080;
            6:  v.cand = 64'h8000000000000000;
            7:  v.cand = 64'h0000000100000000;
            8:  v.cand = 64'h00000000ffffffff;
            9:  v.cand = 64'hffffffff00000000;
            10: v.cand = 64'h0000000000000001;
            11: v.cand = 64'h5555555555555555;
            12: v.cand = 64'haaaaaaaaaaaaaaaa;
            default: v.cand = 64'h7f7f7f7f7f7f7f7f;
        endcase
        return v;
    endfunction

    function automatic logic [md5cm_pkg::CAND_W-1:0] rand_candidate();
        case ($urandom_range(0, 3))
            0:       return {$urandom, $urandom};
            1:       return {$urandom, $urandom} | 64'h8080808080808080;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return ~(64'd1 << $urandom_range(0, 63));
        endcase
    endfunction

    // Sender gap: bursts with no idling, otherwise half zero, half 0..18
    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic send_candidate(input logic [md5cm_pkg::CAND_W-1:0] cand,
                                  input logic typed, input t_digest typed_res);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_candidate <= cand;
        do @(posedge i_clk); while (o_busy);
        pending_digests.push_back(typed ? typed_res : md5_expect(cand));
    endtask

    // Hold off until every expected digest has come back
    task automatic drain();
        i_start <= 1'b0;
        while (pending_digests.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [md5cm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [md5cm_pkg::WORD_W-1:0] data);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            md5cm_pkg::REG_TARGET_A: tgt_a = data;
            md5cm_pkg::REG_TARGET_B: tgt_b = data;
            md5cm_pkg::REG_TARGET_C: tgt_c = data;
            md5cm_pkg::REG_TARGET_D: tgt_d = data;
            default: ;   // unmapped index, write dropped
        endcase
    endtask

    function automatic logic [md5cm_pkg::CFG_IDX_W-1:0] stray_index();
        return md5cm_pkg::CFG_IDX_W'($urandom_range(int'(md5cm_pkg::REG_TARGET_D) + 1,
                                                    (1 << md5cm_pkg::CFG_IDX_W) - 1));
    endfunction

    task automatic load_targets(input logic [md5cm_pkg::WORD_W-1:0] a,
                                input logic [md5cm_pkg::WORD_W-1:0] b,
                                input logic [md5cm_pkg::WORD_W-1:0] c,
                                input logic [md5cm_pkg::WORD_W-1:0] d);
        int stray;
        stray = $urandom_range(0, 5);
        if (stray == 0) write_reg(stray_index(), $urandom);
        write_reg(md5cm_pkg::REG_TARGET_A, a);
        write_reg(md5cm_pkg::REG_TARGET_B, b);
        if (stray == 1) write_reg(stray_index(), $urandom);
        write_reg(md5cm_pkg::REG_TARGET_C, c);
        write_reg(md5cm_pkg::REG_TARGET_D, d);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        t_digest want;
        if (i_rst_n && o_valid) begin
            if (pending_digests.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: %h %h %h %h match %b",
                             o_digest_a, o_digest_b, o_digest_c, o_digest_d, o_match);
            end else begin
                want = pending_digests.pop_front();
                if (o_digest_a !== want.a || o_digest_b !== want.b ||
                    o_digest_c !== want.c || o_digest_d !== want.d ||
                    o_match !== want.match) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("digest mismatch: exp %h %h %h %h m%b got %h %h %h %h m%b",
                                 want.a, want.b, want.c, want.d, want.match,
                                 o_digest_a, o_digest_b, o_digest_c, o_digest_d, o_match);
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("md5_candidate_match_core verification failed");
        $finish;
    end

    initial begin
        t_dir_row                     row;
        t_digest                      hit_dig;
        logic [md5cm_pkg::CAND_W-1:0] hit;
        logic [md5cm_pkg::CAND_W-1:0] cand;
        logic [md5cm_pkg::WORD_W-1:0] mask;
        int                           sel;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows against reset targets
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_vector(i);
            send_candidate(row.cand, row.typed, row.res);
        end
        drain();

        // Exact hit on a known digest, a one-bit near miss, then the exact hit again
        load_targets(PWD_A, PWD_B, PWD_C, PWD_D);
        send_candidate(PWD_CAND, 1'b1, {PWD_A, PWD_B, PWD_C, PWD_D, 1'b1});
        send_candidate(PWD_CAND ^ (64'd1 << $urandom_range(0, 63)), 1'b0, '0);
        send_candidate(PWD_CAND, 1'b0, '0);
        drain();

        load_targets('1, '1, '1, '1);
        send_candidate('1, 1'b0, '0);
        send_candidate(rand_candidate(), 1'b0, '0);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            hit     = rand_candidate();
            hit_dig = md5_expect(hit);
            case ($urandom_range(0, 4))
                0, 1: load_targets(hit_dig.a, hit_dig.b, hit_dig.c, hit_dig.d);
                2: begin
                    // three words agree, one differs by a single bit
                    sel  = $urandom_range(0, 3);
                    mask = 32'd1 << $urandom_range(0, 31);
                    load_targets(hit_dig.a ^ ((sel == 0) ? mask : '0),
                                 hit_dig.b ^ ((sel == 1) ? mask : '0),
                                 hit_dig.c ^ ((sel == 2) ? mask : '0),
                                 hit_dig.d ^ ((sel == 3) ? mask : '0));
                end
                3: load_targets($urandom, $urandom, $urandom, $urandom);
                default: begin
                    if ($urandom_range(0, 1) == 0) load_targets('0, '0, '0, '0);
                    else load_targets('1, '1, '1, '1);
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: cand = hit;
                    3, 4:    cand = hit ^ (64'd1 << $urandom_range(0, 63));
                    default: cand = rand_candidate();
                endcase
                send_candidate(cand, 1'b0, '0);
                if ($urandom_range(0, 59) == 0) drain();
            end
            drain();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && pending_digests.size() == 0)
            $display("md5_candidate_match_core verification clean");
        else
            $display("md5_candidate_match_core verification failed");
        $finish;
    end

endmodule
